FILE: design/bitmap_text_renderer_core_macros.svh
// ----------------------------------------------------------------------------
// Bitmap text renderer assertion macros
// Concurrent assertion wrappers used by the renderer rasterizer.
// ----------------------------------------------------------------------------
`ifndef BITMAP_TEXT_RENDERER_CORE_MACROS_SVH
`define BITMAP_TEXT_RENDERER_CORE_MACROS_SVH

// prop must hold at every clock edge outside reset
`define BTR_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("btr assertion failed");

// cond must never be true outside reset
`define BTR_ASSERT_NEVER(name, clk, rstn, cond) \
    `BTR_ASSERT(name, clk, rstn, !(cond))

`endif

FILE: design/btr_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap text renderer package
// Shared constants, codes and payload types of the text renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package btr_pkg;

    localparam int GLYPH_STORE_BYTES = 65536;
    localparam int STORE_AW          = $clog2(GLYPH_STORE_BYTES);
    localparam int MAX_GLYPH_ROWS    = 64;
    localparam int ROW_W             = $clog2(MAX_GLYPH_ROWS);
    localparam int TAB_COLUMNS       = 4;

    localparam logic [6:0] MAX_ROWS_H = 7'(MAX_GLYPH_ROWS);

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_BEGIN  = 2'd1;
    localparam logic [1:0] OP_RENDER = 2'd2;

    localparam logic [1:0] CFG_GLYPH_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_GLYPH_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_SCREEN_WIDTH = 2'd2;
    localparam logic [1:0] CFG_DRAW_COLOR   = 2'd3;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] font_addr;
        logic [7:0]  font_byte;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [7:0]  ch;
    } in_item_t;

    typedef struct packed {
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic [31:0] row_mask;
        logic        last_row;
    } out_item_t;

    typedef struct packed {
        logic [STORE_AW-1:0] addr;
        logic [15:0]         px;
        logic [15:0]         py;
        logic [1:0]          stride_m1;
        logic [ROW_W-1:0]    h_m1;
        logic [31:0]         wmask;
    } job_t;

endpackage

`default_nettype wire

FILE: design/btr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module btr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/btr_layout.sv
// ----------------------------------------------------------------------------
// Text layout controller
// Takes input requests and register writes, keeps the pen state, writes
// glyph bytes and hands one glyph job at a time to the rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

module btr_layout import btr_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire in_item_t            s_data,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [31:0]         cfg_wdata,
    output logic                     ram_we,
    output logic [STORE_AW-1:0]      ram_waddr,
    output logic [7:0]               ram_wdata,
    output logic                     job_start,
    output job_t                     job,
    input  wire logic                raster_busy
);

    typedef enum logic [2:0] {ST_IDLE, ST_WRAP, ST_BASE, ST_START, ST_WAIT} state_t;

    state_t      state_reg;
    logic [5:0]  glyph_width_reg;
    logic [6:0]  glyph_height_reg;
    logic [12:0] screen_width_reg;
    logic [11:0] origin_x_reg;
    logic [15:0] cursor_y_reg;
    logic [15:0] column_count_reg;
    logic [7:0]  ch_reg;
    logic [9:0]  sh_reg;
    job_t        job_reg;

    logic [5:0]  w_eff;
    logic [6:0]  h_eff;
    logic [5:0]  w_p7;
    logic [2:0]  stride;
    logic [16:0] cc_p1;
    logic [22:0] wrap_prod;
    logic [21:0] col_px;
    logic [17:0] base_prod;
    logic [31:0] wmask;
    logic [15:0] cursor_down;
    logic        accept;

    always_comb begin
        if (glyph_width_reg == 6'd0) begin
            w_eff = 6'd1;
        end else if (glyph_width_reg > 6'd32) begin
            w_eff = 6'd32;
        end else begin
            w_eff = glyph_width_reg;
        end
        if (glyph_height_reg == 7'd0) begin
            h_eff = 7'd1;
        end else if (glyph_height_reg > MAX_ROWS_H) begin
            h_eff = MAX_ROWS_H;
        end else begin
            h_eff = glyph_height_reg;
        end
    end

    assign w_p7        = w_eff + 6'd7;
    assign stride      = w_p7[5:3];
    assign cc_p1       = {1'b0, column_count_reg} + 17'd1;
    assign wrap_prod   = {6'b0, cc_p1} * {17'b0, w_eff};
    assign col_px      = {6'b0, column_count_reg} * {16'b0, w_eff};
    assign base_prod   = {10'b0, ch_reg} * {8'b0, sh_reg};
    assign wmask       = (w_eff == 6'd32) ? '1 : ((32'd1 << w_eff) - 32'd1);
    assign cursor_down = cursor_y_reg + {9'b0, h_eff};

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign ram_we    = accept && (s_data.op == OP_LOAD);
    assign ram_waddr = STORE_AW'(s_data.font_addr);
    assign ram_wdata = s_data.font_byte;
    assign job_start = (state_reg == ST_START);
    assign job       = job_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            glyph_width_reg  <= 6'd8;
            glyph_height_reg <= 7'd16;
            screen_width_reg <= 13'd1024;
            origin_x_reg     <= '0;
            cursor_y_reg     <= '0;
            column_count_reg <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_GLYPH_WIDTH:  glyph_width_reg  <= cfg_wdata[5:0];
                    CFG_GLYPH_HEIGHT: glyph_height_reg <= cfg_wdata[6:0];
                    CFG_SCREEN_WIDTH: screen_width_reg <= cfg_wdata[12:0];
                    CFG_DRAW_COLOR:   ; // draw color is not used by the renderer
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (s_data.op == OP_BEGIN) begin
                            origin_x_reg     <= s_data.pos_x;
                            cursor_y_reg     <= {4'b0, s_data.pos_y};
                            column_count_reg <= '0;
                        end else if (s_data.op == OP_RENDER) begin
                            unique case (s_data.ch)
                                CH_NUL: ;
                                CH_CR: column_count_reg <= '0;
                                CH_LF: begin
                                    column_count_reg <= '0;
                                    cursor_y_reg     <= cursor_down;
                                end
                                CH_TAB: column_count_reg <= column_count_reg
                                                            + 16'(TAB_COLUMNS);
                                default: begin
                                    ch_reg    <= s_data.ch;
                                    state_reg <= ST_WRAP;
                                end
                            endcase
                        end
                    end
                end
                ST_WRAP: begin
                    if (wrap_prod > {10'b0, screen_width_reg}) begin
                        column_count_reg <= '0;
                        cursor_y_reg     <= cursor_down;
                    end
                    sh_reg    <= {7'b0, stride} * {3'b0, h_eff};
                    state_reg <= ST_BASE;
                end
                ST_BASE: begin
                    job_reg.addr      <= STORE_AW'(base_prod);
                    job_reg.px        <= 16'({10'b0, origin_x_reg} + col_px);
                    job_reg.py        <= cursor_y_reg;
                    job_reg.stride_m1 <= 2'(stride - 3'd1);
                    job_reg.h_m1      <= ROW_W'(h_eff - 7'd1);
                    job_reg.wmask     <= wmask;
                    column_count_reg  <= column_count_reg + 16'd1;
                    state_reg         <= ST_START;
                end
                ST_START: state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (!raster_busy) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: design/btr_raster.sv
// ----------------------------------------------------------------------------
// Glyph rasterizer
// Streams glyph bytes from the glyph store one per cycle unless the output
// stalls, builds row masks and holds finished rows in the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bitmap_text_renderer_core_macros.svh"

module btr_raster import btr_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                job_start,
    input  wire job_t                job,
    output logic                     busy,
    output logic                     ram_re,
    output logic [STORE_AW-1:0]      ram_raddr,
    input  wire logic [7:0]          ram_rdata,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output out_item_t                m_data
);

    job_t                job_reg;
    logic                active_reg;
    logic [STORE_AW-1:0] addr_reg;
    logic [1:0]          iss_byte_reg;
    logic [ROW_W-1:0]    iss_row_reg;
    logic                ret_valid_reg;
    logic [1:0]          ret_byte_reg;
    logic                ret_last_byte_reg;
    logic [ROW_W-1:0]    ret_row_reg;
    logic                ret_last_row_reg;
    logic [31:0]         acc_reg;
    logic                m_valid_reg;
    out_item_t           m_data_reg;

    logic        out_free;
    logic        consume;
    logic        rd_en;
    logic        iss_last_byte;
    logic        iss_last_row;
    logic [7:0]  rev;
    logic [31:0] placed;
    logic [31:0] merged;

    assign out_free      = !m_valid_reg || m_ready;
    assign consume       = ret_valid_reg && (!ret_last_byte_reg || out_free);
    assign rd_en         = active_reg && (!ret_valid_reg || consume);
    assign iss_last_byte = (iss_byte_reg == job_reg.stride_m1);
    assign iss_last_row  = (iss_row_reg == job_reg.h_m1);

    // leftmost pixel is the byte's MSB and lands in the lowest mask bit
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            rev[i] = ram_rdata[7 - i];
        end
    end

    assign placed = {24'b0, rev} << {ret_byte_reg, 3'b000};
    assign merged = ((ret_byte_reg == 2'd0) ? 32'd0 : acc_reg) | placed;

    assign busy      = active_reg || ret_valid_reg;
    assign ram_re    = rd_en;
    assign ram_raddr = addr_reg;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            ret_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (job_start) begin
                active_reg <= 1'b1;
            end else if (rd_en && iss_last_byte && iss_last_row) begin
                active_reg <= 1'b0;
            end
            if (rd_en) begin
                ret_valid_reg <= 1'b1;
            end else if (consume) begin
                ret_valid_reg <= 1'b0;
            end
            if (consume && ret_last_byte_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job_start) begin
            job_reg      <= job;
            addr_reg     <= job.addr;
            iss_byte_reg <= '0;
            iss_row_reg  <= '0;
        end else if (rd_en) begin
            addr_reg <= addr_reg + STORE_AW'(1);
            if (iss_last_byte) begin
                iss_byte_reg <= '0;
                iss_row_reg  <= iss_row_reg + ROW_W'(1);
            end else begin
                iss_byte_reg <= iss_byte_reg + 2'd1;
            end
        end
        if (rd_en) begin
            ret_byte_reg      <= iss_byte_reg;
            ret_last_byte_reg <= iss_last_byte;
            ret_row_reg       <= iss_row_reg;
            ret_last_row_reg  <= iss_last_row;
        end
        if (consume && !ret_last_byte_reg) begin
            acc_reg <= merged;
        end
        if (consume && ret_last_byte_reg) begin
            m_data_reg.pixel_x  <= job_reg.px;
            m_data_reg.pixel_y  <= job_reg.py + 16'(ret_row_reg);
            m_data_reg.row_mask <= merged & job_reg.wmask;
            m_data_reg.last_row <= ret_last_row_reg;
        end
    end

    `BTR_ASSERT_NEVER(a_start_idle, aclk, aresetn, job_start && busy)
    `BTR_ASSERT(a_last_row_ends, aclk, aresetn,
        (consume && ret_last_byte_reg && ret_last_row_reg) |=> !busy)
    `BTR_ASSERT(a_rdata_held, aclk, aresetn,
        (ret_valid_reg && !consume) |=> $stable(ram_rdata))

endmodule

`default_nettype wire

FILE: design/bitmap_text_renderer_core.sv
// ----------------------------------------------------------------------------
// Bitmap text renderer core
// Lays out character codes in a bitmap font and emits one pixel mask per
// glyph row.
//
// Input channel s_*: load requests write one glyph store byte, begin
// requests set the pen origin, render requests handle one character code.
// Load, begin, NUL, CR, LF and TAB leave the block idle and give no result.
// A drawn glyph gives one m_* result per glyph row. It occupies the block
// from the accept through the setup states ST_WRAP, ST_BASE and ST_START,
// then stride * height store reads (stride = ceil(width / 8)), one per
// cycle unless the output stalls, through the single read port of the
// store RAM, until the last byte has returned and the block goes idle.
// The default glyph is 8x16. The user must write registers over cfg_*
// only while the block is idle; the block itself does not enforce this.
// A stalled m_ready holds the finished row in the output register and
// stops the store reads; the next request is taken once the last row of
// the glyph has reached the output register.
// Reset restores the register defaults and clears the pen; the glyph
// store is not cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_text_renderer_core import btr_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    logic                ram_we;
    logic [STORE_AW-1:0] ram_waddr;
    logic [7:0]          ram_wdata;
    logic                ram_re;
    logic [STORE_AW-1:0] ram_raddr;
    logic [7:0]          ram_rdata;
    logic                job_start;
    job_t                job;
    logic                raster_busy;

    btr_layout u_layout (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .job_start   (job_start),
        .job         (job),
        .raster_busy (raster_busy)
    );

    btr_ram #(
        .WIDTH (8),
        .DEPTH (GLYPH_STORE_BYTES)
    ) u_glyph_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    btr_raster u_raster (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_start (job_start),
        .job       (job),
        .busy      (raster_busy),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
